// ===== hw/rtl/gn3d_pkg.sv =====
package gn3d_pkg;

    // Gradient direction, one signed unit step per axis
    typedef struct packed {
        logic signed [1:0] gx;
        logic signed [1:0] gy;
        logic signed [1:0] gz;
    } grad_t;

    // Permutation table write request, issued on a load transfer
    typedef struct packed {
        logic       valid;
        logic [7:0] index;
        logic [7:0] value;
    } perm_wr_t;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_kind_t;

    localparam logic [3:0] TABLE_LOG2_RESET = 4'd8;
    localparam int         PIPE_STAGES      = 8;
    localparam int         OUT_W            = 24;

    // 16-entry gradient set, indexed by the low hash nibble
    function automatic grad_t grad_lookup(input logic [3:0] h);
        grad_t g;
        case (h)
            4'd0:    g = '{ 2'sd1,  2'sd1,  2'sd0};
            4'd1:    g = '{-2'sd1,  2'sd1,  2'sd0};
            4'd2:    g = '{ 2'sd1, -2'sd1,  2'sd0};
            4'd3:    g = '{-2'sd1, -2'sd1,  2'sd0};
            4'd4:    g = '{ 2'sd1,  2'sd0,  2'sd1};
            4'd5:    g = '{-2'sd1,  2'sd0,  2'sd1};
            4'd6:    g = '{ 2'sd1,  2'sd0, -2'sd1};
            4'd7:    g = '{-2'sd1,  2'sd0, -2'sd1};
            4'd8:    g = '{ 2'sd0,  2'sd1,  2'sd1};
            4'd9:    g = '{ 2'sd0, -2'sd1,  2'sd1};
            4'd10:   g = '{ 2'sd0,  2'sd1, -2'sd1};
            4'd11:   g = '{ 2'sd0, -2'sd1, -2'sd1};
            4'd12:   g = '{ 2'sd1,  2'sd1,  2'sd0};
            4'd13:   g = '{-2'sd1,  2'sd1,  2'sd0};
            4'd14:   g = '{ 2'sd0, -2'sd1,  2'sd1};
            4'd15:   g = '{ 2'sd0, -2'sd1, -2'sd1};
            default: g = '{ 2'sd0,  2'sd0,  2'sd0};
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/gradient_noise_3d_with_derivatives.sv =====
// 3D gradient noise with analytic derivatives, fixed point.
// A sample transfer gives its result at the output register.
// Throughput: one transfer per cycle unless the output stalls; three dependent
// table reads set the depth, served by seven two-port permutation table copies.
// Reset clears the pipeline valids and sets table_size_log2 to 8;
// the permutation table is not cleared and must be loaded before use.
module gradient_noise_3d_with_derivatives #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         load_index,
    input  logic [7:0]         load_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] noise_value,
    output logic signed [23:0] slope_x,
    output logic signed [23:0] slope_y,
    output logic signed [23:0] slope_z
);

    import gn3d_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                        en;
    logic                        accept;
    logic                        smp_in;
    perm_wr_t                    wr;
    logic [3:0]                  table_size_log2_reg;
    logic [3:0]                  lg_eff;
    logic [AW-1:0]               mask;
    logic signed [31+AW:0]       px_ext;
    logic signed [31+AW:0]       py_ext;
    logic signed [31+AW:0]       pz_ext;
    logic [AW-1:0]               cell_x;
    logic [AW-1:0]               cell_y;
    logic [AW-1:0]               cell_z;
    logic [3:0]                  hash [8];
    logic [FRAC_BITS-1:0]        t_s3  [3];
    logic signed [FRAC_BITS+6:0] f_s3  [3];
    logic signed [FRAC_BITS+6:0] df_s3 [3];
    logic signed [23:0]          noise_sat;
    logic signed [23:0]          slope_sat [3];

    logic [PIPE_STAGES:1]        v_reg;
    logic                        out_valid_reg;
    logic signed [23:0]          noise_reg;
    logic signed [23:0]          slope_x_reg;
    logic signed [23:0]          slope_y_reg;
    logic signed [23:0]          slope_z_reg;

    // whole pipeline advances unless a held result is stalled
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;
    assign accept   = in_valid && en;
    assign smp_in   = accept && (req_type == REQ_SAMPLE);

    assign wr.valid = accept && (req_type == REQ_LOAD);
    assign wr.index = load_index;
    assign wr.value = load_value;

    // table size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_log2_reg <= TABLE_LOG2_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_size_log2_reg <= cfg_wr_data;
        end
    end

    // zero acts as one; sizes beyond the table saturate
    assign lg_eff = (table_size_log2_reg == 4'd0) ? 4'd1 : table_size_log2_reg;

    always_comb
    begin
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (i < int'(lg_eff));
        end
    end

    // integer cell, floor of the coordinate
    assign px_ext = {{AW{point_x[31]}}, point_x};
    assign py_ext = {{AW{point_y[31]}}, point_y};
    assign pz_ext = {{AW{point_z[31]}}, point_z};
    assign cell_x = px_ext[FRAC_BITS +: AW] & mask;
    assign cell_y = py_ext[FRAC_BITS +: AW] & mask;
    assign cell_z = pz_ext[FRAC_BITS +: AW] & mask;

    gn3d_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .wr     (wr),
        .mask   (mask),
        .cell_x (cell_x),
        .cell_y (cell_y),
        .cell_z (cell_z),
        .hash   (hash)
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .clk   (clk),
        .en    (en),
        .t     (point_x[FRAC_BITS-1:0]),
        .t_out (t_s3[0]),
        .fade  (f_s3[0]),
        .dfade (df_s3[0])
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .clk   (clk),
        .en    (en),
        .t     (point_y[FRAC_BITS-1:0]),
        .t_out (t_s3[1]),
        .fade  (f_s3[1]),
        .dfade (df_s3[1])
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
        .clk   (clk),
        .en    (en),
        .t     (point_z[FRAC_BITS-1:0]),
        .t_out (t_s3[2]),
        .fade  (f_s3[2]),
        .dfade (df_s3[2])
    );

    gn3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .clk       (clk),
        .en        (en),
        .hash      (hash),
        .t         (t_s3),
        .fade      (f_s3),
        .dfade     (df_s3),
        .noise_sat (noise_sat),
        .slope_sat (slope_sat)
    );

    // sample valids along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[PIPE_STAGES-1:1], smp_in};
            out_valid_reg <= v_reg[PIPE_STAGES];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise_reg   <= noise_sat;
            slope_x_reg <= slope_sat[0];
            slope_y_reg <= slope_sat[1];
            slope_z_reg <= slope_sat[2];
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;
    assign slope_x     = slope_x_reg;
    assign slope_y     = slope_y_reg;
    assign slope_z     = slope_z_reg;

`ifndef SYNTHESIS
    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_SAMPLE) |=> v_reg[1])
        else $error("sample transfer did not enter the pipeline");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_LOAD) |=> !v_reg[1])
        else $error("load transfer started a result");

    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(v_reg))
        else $error("pipeline moved while the output was stalled");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_reg[PIPE_STAGES]))
        else $error("result appeared without a sample in the last stage");
`endif

endmodule

// ===== hw/rtl/gn3d_perm_mem.sv =====
module gn3d_perm_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [7:0]    rdata0,
    output logic [7:0]    rdata1
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata0_reg;
    logic [7:0] rdata1_reg;

    // one write port, two registered read ports; reads see the old entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== hw/rtl/gn3d_hash.sv =====
module gn3d_hash #(
    parameter int TABLE_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  gn3d_pkg::perm_wr_t  wr,
    input  logic [AW-1:0]       mask,
    input  logic [AW-1:0]       cell_x,
    input  logic [AW-1:0]       cell_y,
    input  logic [AW-1:0]       cell_z,
    output logic [3:0]          hash [8]
);

    import gn3d_pkg::*;

    localparam int IW     = AW + 9;
    localparam int COPIES = 7;

    logic [IW-1:0] idx_ext;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;

    logic          ld1_v_reg;
    logic [AW-1:0] ld1_addr_reg;
    logic [7:0]    ld1_data_reg;
    logic          ld2_v_reg;
    logic [AW-1:0] ld2_addr_reg;
    logic [7:0]    ld2_data_reg;

    logic [AW-1:0] cy1_reg;
    logic [AW-1:0] cz1_reg;
    logic [AW-1:0] cz2_reg;

    logic          m_we    [COPIES];
    logic [AW-1:0] m_waddr [COPIES];
    logic [7:0]    m_wdata [COPIES];
    logic [AW-1:0] m_ra0   [COPIES];
    logic [AW-1:0] m_ra1   [COPIES];
    logic [7:0]    m_rd0   [COPIES];
    logic [7:0]    m_rd1   [COPIES];

    logic [AW-1:0] a_base;
    logic [AW-1:0] b_base;
    logic [AW-1:0] aa_base;
    logic [AW-1:0] ab_base;
    logic [AW-1:0] ba_base;
    logic [AW-1:0] bb_base;

    // loads beyond the table are dropped
    assign idx_ext = IW'(wr.index);
    assign wr_ok   = wr.valid && (idx_ext < IW'(TABLE_DEPTH));
    assign wr_addr = AW'(wr.index);

    // load write travels with the samples so each copy is written
    // at the stage where it is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld1_v_reg <= 1'b0;
            ld2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            ld1_v_reg <= wr_ok;
            ld2_v_reg <= ld1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ld1_addr_reg <= wr_addr;
            ld1_data_reg <= wr.value;
            ld2_addr_reg <= ld1_addr_reg;
            ld2_data_reg <= ld1_data_reg;
            cy1_reg      <= cell_y;
            cz1_reg      <= cell_z;
            cz2_reg      <= cz1_reg;
        end
    end

    // level 1: x cell
    assign a_base = AW'(m_rd0[0]) + cy1_reg;
    assign b_base = AW'(m_rd1[0]) + cy1_reg;

    // level 2 bases, from copies 1 and 2
    assign aa_base = AW'(m_rd0[1]) + cz2_reg;
    assign ab_base = AW'(m_rd1[1]) + cz2_reg;
    assign ba_base = AW'(m_rd0[2]) + cz2_reg;
    assign bb_base = AW'(m_rd1[2]) + cz2_reg;

    always_comb
    begin
        m_ra0[0] = cell_x & mask;
        m_ra1[0] = (cell_x + AW'(1)) & mask;
        m_ra0[1] = a_base & mask;
        m_ra1[1] = (a_base + AW'(1)) & mask;
        m_ra0[2] = b_base & mask;
        m_ra1[2] = (b_base + AW'(1)) & mask;
        m_ra0[3] = aa_base & mask;
        m_ra1[3] = (aa_base + AW'(1)) & mask;
        m_ra0[4] = ba_base & mask;
        m_ra1[4] = (ba_base + AW'(1)) & mask;
        m_ra0[5] = ab_base & mask;
        m_ra1[5] = (ab_base + AW'(1)) & mask;
        m_ra0[6] = bb_base & mask;
        m_ra1[6] = (bb_base + AW'(1)) & mask;

        m_we[0]    = en && wr_ok;
        m_waddr[0] = wr_addr;
        m_wdata[0] = wr.value;
        for (int c = 1; c < 3; c++)
        begin
            m_we[c]    = en && ld1_v_reg;
            m_waddr[c] = ld1_addr_reg;
            m_wdata[c] = ld1_data_reg;
        end
        for (int c = 3; c < COPIES; c++)
        begin
            m_we[c]    = en && ld2_v_reg;
            m_waddr[c] = ld2_addr_reg;
            m_wdata[c] = ld2_data_reg;
        end
    end

    // replicated table copies, two reads each
    for (genvar c = 0; c < COPIES; c++)
    begin : g_copy
        gn3d_perm_mem #(
            .DEPTH (TABLE_DEPTH),
            .AW    (AW)
        ) u_mem (
            .clk    (clk),
            .en     (en),
            .we     (m_we[c]),
            .waddr  (m_waddr[c]),
            .wdata  (m_wdata[c]),
            .raddr0 (m_ra0[c]),
            .raddr1 (m_ra1[c]),
            .rdata0 (m_rd0[c]),
            .rdata1 (m_rd1[c])
        );
    end

    // corner hashes, bit0 = x+1, bit1 = y+1, bit2 = z+1
    assign hash[0] = m_rd0[3][3:0];
    assign hash[4] = m_rd1[3][3:0];
    assign hash[1] = m_rd0[4][3:0];
    assign hash[5] = m_rd1[4][3:0];
    assign hash[2] = m_rd0[5][3:0];
    assign hash[6] = m_rd1[5][3:0];
    assign hash[3] = m_rd0[6][3:0];
    assign hash[7] = m_rd1[6][3:0];

endmodule

// ===== hw/rtl/gn3d_fade.sv =====
module gn3d_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [FRAC_BITS-1:0]         t,
    output logic [FRAC_BITS-1:0]         t_out,
    output logic signed [FRAC_BITS+6:0]  fade,
    output logic signed [FRAC_BITS+6:0]  dfade
);

    localparam int FW = FRAC_BITS + 7;
    localparam logic signed [FW-1:0]   ONE  = FW'(1) <<< FRAC_BITS;
    localparam logic signed [2*FW-1:0] HALF = (2*FW)'(1) <<< (FRAC_BITS - 1);

    function automatic logic signed [FW-1:0] mulq(input logic signed [FW-1:0] a,
                                                 input logic signed [FW-1:0] b);
        logic signed [2*FW-1:0] p;
        p = a * b;
        p = p + HALF;
        return FW'(p >>> FRAC_BITS);
    endfunction

    logic signed [FW-1:0] tv;
    logic [FRAC_BITS-1:0] t1_reg;
    logic [FRAC_BITS-1:0] t2p_reg;
    logic [FRAC_BITS-1:0] t3p_reg;
    logic signed [FW-1:0] sq_reg;
    logic signed [FW-1:0] q1_reg;
    logic signed [FW-1:0] r1_reg;
    logic signed [FW-1:0] cube_reg;
    logic signed [FW-1:0] q2_reg;
    logic signed [FW-1:0] df2_reg;
    logic signed [FW-1:0] f3_reg;
    logic signed [FW-1:0] df3_reg;
    logic signed [FW-1:0] t1v;

    assign tv  = $signed({{(FW-FRAC_BITS){1'b0}}, t});
    assign t1v = $signed({{(FW-FRAC_BITS){1'b0}}, t1_reg});

    // square and the two polynomial tails
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t;
            sq_reg <= mulq(tv, tv);
            q1_reg <= mulq(tv, FW'(6 * tv - 15 * ONE)) + FW'(10 * ONE);
            r1_reg <= mulq(tv, FW'(30 * tv - 60 * ONE)) + FW'(30 * ONE);
        end
    end

    // cube and derivative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2p_reg  <= t1_reg;
            cube_reg <= mulq(sq_reg, t1v);
            q2_reg   <= q1_reg;
            df2_reg  <= mulq(sq_reg, r1_reg);
        end
    end

    // quintic fade
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3p_reg <= t2p_reg;
            f3_reg  <= mulq(cube_reg, q2_reg);
            df3_reg <= df2_reg;
        end
    end

    assign t_out = t3p_reg;
    assign fade  = f3_reg;
    assign dfade = df3_reg;

endmodule

// ===== hw/rtl/gn3d_blend.sv =====
module gn3d_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [3:0]                  hash  [8],
    input  logic [FRAC_BITS-1:0]        t     [3],
    input  logic signed [FRAC_BITS+6:0] fade  [3],
    input  logic signed [FRAC_BITS+6:0] dfade [3],
    output logic signed [23:0]          noise_sat,
    output logic signed [23:0]          slope_sat [3]
);

    import gn3d_pkg::*;

    localparam int VW = FRAC_BITS + 8;
    localparam int CW = ((VW + 1 > OUT_W) ? VW + 1 : OUT_W) + 1;
    localparam logic signed [VW-1:0]   ONE    = VW'(1) <<< FRAC_BITS;
    localparam logic signed [2*VW-1:0] HALF   = (2*VW)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [CW-1:0]   SAT_HI = (CW'(1) <<< (OUT_W - 1)) - CW'(1);
    localparam logic signed [CW-1:0]   SAT_LO = ~SAT_HI;

    function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = a * b;
        p = p + HALF;
        return VW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] m,
                                                 input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
        logic signed [VW-1:0] d;
        d = b - a;
        return a + mulq(m, d);
    endfunction

    function automatic logic signed [VW-1:0] gscale(input logic signed [1:0] g);
        logic signed [VW-1:0] r;
        if (g == 2'sd1)
            r = ONE;
        else if (g == -2'sd1)
            r = -ONE;
        else
            r = '0;
        return r;
    endfunction

    function automatic logic signed [VW-1:0] gterm(input logic signed [1:0] g,
                                                  input logic signed [VW-1:0] off);
        logic signed [VW-1:0] r;
        if (g == 2'sd1)
            r = off;
        else if (g == -2'sd1)
            r = -off;
        else
            r = '0;
        return r;
    endfunction

    function automatic logic [23:0] sat(input logic signed [VW:0] v);
        logic signed [CW-1:0] e;
        logic signed [CW-1:0] r;
        e = CW'(v);
        if (e > SAT_HI)
            r = SAT_HI;
        else if (e < SAT_LO)
            r = SAT_LO;
        else
            r = e;
        return r[23:0];
    endfunction

    // corner values
    grad_t                g_c   [8];
    logic signed [VW-1:0] val_c [8];
    logic signed [VW-1:0] tv    [3];

    logic signed [VW-1:0] val4_reg [8];
    grad_t                g4_reg   [8];
    logic signed [VW-1:0] f4_reg   [3];
    logic signed [VW-1:0] df4_reg  [3];

    // x level
    logic signed [VW-1:0] nx_reg  [4];
    logic signed [VW-1:0] gxx_reg [4];
    logic signed [VW-1:0] gyx_reg [4];
    logic signed [VW-1:0] gzx_reg [4];
    logic signed [VW-1:0] dx_reg  [4];
    logic signed [VW-1:0] yd5_reg [2];
    logic signed [VW-1:0] zd5_reg [2];
    logic signed [VW-1:0] fy5_reg;
    logic signed [VW-1:0] fz5_reg;
    logic signed [VW-1:0] df5_reg [3];

    // y level
    logic signed [VW-1:0] ny_reg  [2];
    logic signed [VW-1:0] gxy_reg [2];
    logic signed [VW-1:0] gyy_reg [2];
    logic signed [VW-1:0] gzy_reg [2];
    logic signed [VW-1:0] dxy_reg [2];
    logic signed [VW-1:0] yd6_reg [2];
    logic signed [VW-1:0] zb6_reg;
    logic signed [VW-1:0] fz6_reg;
    logic signed [VW-1:0] df6_reg [3];

    // z level
    logic signed [VW-1:0] n7_reg;
    logic signed [VW-1:0] g7_reg  [3];
    logic signed [VW-1:0] b7_reg  [3];
    logic signed [VW-1:0] df7_reg [3];

    // derivative products
    logic signed [VW-1:0] n8_reg;
    logic signed [VW-1:0] g8_reg [3];
    logic signed [VW-1:0] m8_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tv[k] = $signed({{(VW-FRAC_BITS){1'b0}}, t[k]});
        end
        for (int i = 0; i < 8; i++)
        begin
            g_c[i]   = grad_lookup(hash[i]);
            val_c[i] = gterm(g_c[i].gx, i[0] ? tv[0] - ONE : tv[0])
                     + gterm(g_c[i].gy, i[1] ? tv[1] - ONE : tv[1])
                     + gterm(g_c[i].gz, i[2] ? tv[2] - ONE : tv[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                val4_reg[i] <= val_c[i];
                g4_reg[i]   <= g_c[i];
            end
            for (int k = 0; k < 3; k++)
            begin
                f4_reg[k]  <= VW'(fade[k]);
                df4_reg[k] <= VW'(dfade[k]);
            end
        end
    end

    // blend along x
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                nx_reg[j]  <= lerp(f4_reg[0], val4_reg[2*j], val4_reg[2*j+1]);
                gxx_reg[j] <= lerp(f4_reg[0], gscale(g4_reg[2*j].gx),
                                   gscale(g4_reg[2*j+1].gx));
                gyx_reg[j] <= lerp(f4_reg[0], gscale(g4_reg[2*j].gy),
                                   gscale(g4_reg[2*j+1].gy));
                gzx_reg[j] <= lerp(f4_reg[0], gscale(g4_reg[2*j].gz),
                                   gscale(g4_reg[2*j+1].gz));
                dx_reg[j]  <= val4_reg[2*j+1] - val4_reg[2*j];
            end
            yd5_reg[0] <= lerp(f4_reg[0], val4_reg[2] - val4_reg[0],
                               val4_reg[3] - val4_reg[1]);
            yd5_reg[1] <= lerp(f4_reg[0], val4_reg[6] - val4_reg[4],
                               val4_reg[7] - val4_reg[5]);
            zd5_reg[0] <= lerp(f4_reg[0], val4_reg[4] - val4_reg[0],
                               val4_reg[5] - val4_reg[1]);
            zd5_reg[1] <= lerp(f4_reg[0], val4_reg[6] - val4_reg[2],
                               val4_reg[7] - val4_reg[3]);
            fy5_reg    <= f4_reg[1];
            fz5_reg    <= f4_reg[2];
            df5_reg    <= df4_reg;
        end
    end

    // blend along y
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                ny_reg[j]  <= lerp(fy5_reg, nx_reg[2*j], nx_reg[2*j+1]);
                gxy_reg[j] <= lerp(fy5_reg, gxx_reg[2*j], gxx_reg[2*j+1]);
                gyy_reg[j] <= lerp(fy5_reg, gyx_reg[2*j], gyx_reg[2*j+1]);
                gzy_reg[j] <= lerp(fy5_reg, gzx_reg[2*j], gzx_reg[2*j+1]);
                dxy_reg[j] <= lerp(fy5_reg, dx_reg[2*j], dx_reg[2*j+1]);
            end
            yd6_reg <= yd5_reg;
            zb6_reg <= lerp(fy5_reg, zd5_reg[0], zd5_reg[1]);
            fz6_reg <= fz5_reg;
            df6_reg <= df5_reg;
        end
    end

    // blend along z
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n7_reg    <= lerp(fz6_reg, ny_reg[0], ny_reg[1]);
            g7_reg[0] <= lerp(fz6_reg, gxy_reg[0], gxy_reg[1]);
            g7_reg[1] <= lerp(fz6_reg, gyy_reg[0], gyy_reg[1]);
            g7_reg[2] <= lerp(fz6_reg, gzy_reg[0], gzy_reg[1]);
            b7_reg[0] <= lerp(fz6_reg, dxy_reg[0], dxy_reg[1]);
            b7_reg[1] <= lerp(fz6_reg, yd6_reg[0], yd6_reg[1]);
            b7_reg[2] <= zb6_reg;
            df7_reg   <= df6_reg;
        end
    end

    // fade derivative times the difference blend
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n8_reg <= n7_reg;
            g8_reg <= g7_reg;
            for (int k = 0; k < 3; k++)
            begin
                m8_reg[k] <= mulq(df7_reg[k], b7_reg[k]);
            end
        end
    end

    // sum and clamp
    always_comb
    begin
        noise_sat = sat((VW+1)'(n8_reg));
        for (int k = 0; k < 3; k++)
        begin
            slope_sat[k] = sat((VW+1)'(g8_reg[k]) + (VW+1)'(m8_reg[k]));
        end
    end

endmodule
